>>> hw/rtl/lkpc_pkg.sv
// ----------------------------------------------------------------------------
// lkpc_pkg
// Shared types, constants and the key name table of the ladder keypad
// press classifier.
// ----------------------------------------------------------------------------
package lkpc_pkg;

    localparam int RD_W      = 12;
    localparam int STEP_W    = 10;
    localparam int SHORT_W   = 8;
    localparam int LONG_W    = 10;
    localparam int KEY_W     = 4;
    localparam int NAME_W    = 3;
    localparam int KIND_W    = 2;
    localparam int QUOT_W    = 3;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DAT_W = 10;

    localparam logic [QUOT_W-1:0] QUOT_NONE = 3'd4;

    localparam logic [CFG_IDX_W-1:0] CFG_ENABLE = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_STEP   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SHORT  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_LONG   = 3'd3;

    localparam logic [KIND_W-1:0] KIND_RELEASE = 2'd0;
    localparam logic [KIND_W-1:0] KIND_SHORT   = 2'd1;
    localparam logic [KIND_W-1:0] KIND_LONG    = 2'd2;

    localparam logic               RST_ENABLE = 1'b1;
    localparam logic [STEP_W-1:0]  RST_STEP   = 10'd930;
    localparam logic [SHORT_W-1:0] RST_SHORT  = 8'd4;
    localparam logic [LONG_W-1:0]  RST_LONG   = 10'd160;

    localparam logic [NAME_W-1:0] KEY_MAP [8] = '{
        3'd5, 3'd0, 3'd1, 3'd4, 3'd6, 3'd2, 3'd3, 3'd7
    };

    typedef struct packed {
        logic [NAME_W-1:0] key_name;
        logic [KIND_W-1:0] press_kind;
        logic              last_event;
    } t_event;

    typedef struct packed {
        logic            start;
        logic [RD_W-1:0] dividend;
    } t_div_ctrl;

    typedef struct packed {
        logic              done;
        logic [QUOT_W-1:0] quot;
    } t_div_status;

    function automatic logic [NAME_W-1:0] key_name_of(input logic [KEY_W-1:0] key);
        logic [2:0] idx;
        idx = key[2:0] - 3'd1;
        return KEY_MAP[idx];
    endfunction

endpackage

>>> hw/rtl/lkpc_div.sv
// ----------------------------------------------------------------------------
// lkpc_div
// Shared subtract and compare unit: quotient of a reading by the ladder
// step, saturating at four.
// ----------------------------------------------------------------------------
module lkpc_div (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  lkpc_pkg::t_div_ctrl          i_ctrl,
    input  logic [lkpc_pkg::STEP_W-1:0]  i_divisor,
    output lkpc_pkg::t_div_status        o_status
);

    logic                         r_busy;
    logic [lkpc_pkg::RD_W-1:0]    r_rem;
    logic [lkpc_pkg::QUOT_W-1:0]  r_q;
    logic [lkpc_pkg::RD_W-1:0]    divisor_ext;
    logic                         sub_ok;

    assign divisor_ext = {{(lkpc_pkg::RD_W - lkpc_pkg::STEP_W){1'b0}}, i_divisor};
    assign sub_ok      = (r_rem >= divisor_ext) && (r_q != lkpc_pkg::QUOT_NONE);

    assign o_status.done = r_busy && !sub_ok;
    assign o_status.quot = r_q;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
        end else if (i_ctrl.start) begin
            r_busy <= 1'b1;
        end else if (r_busy && !sub_ok) begin
            r_busy <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctrl.start) begin
            r_rem <= i_ctrl.dividend;
            r_q   <= '0;
        end else if (r_busy && sub_ok) begin
            r_rem <= r_rem - divisor_ext;
            r_q   <= r_q + 3'd1;
        end
    end

    a_start_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_ctrl.start |=> r_busy)
        else $error("divider not busy after start");

    a_quot_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy |-> (r_q <= lkpc_pkg::QUOT_NONE))
        else $error("divider quotient out of range");

endmodule

>>> hw/rtl/ladder_keypad_press_classifier_top.sv
// ----------------------------------------------------------------------------
// ladder_keypad_press_classifier_top
// Decodes one key from two resistor ladders and emits short, long and
// release events with remapped key names.
// ----------------------------------------------------------------------------
// Flow: the shared divider works on ladder B first, then on ladder A when B shows no key;
// the held-key state and the events of the item are set in S_UPDATE. A new item is not
// taken until the previous one is through and its events have moved to the output.
// Up to two events per item leave one per cycle while the output is not stalled; output
// stalls hold them, and with them the next item.
// Reset: synchronous, active low; config registers return to defaults, no key held.
// ----------------------------------------------------------------------------
module ladder_keypad_press_classifier_top (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_in_valid,
    output logic                            o_in_stall,
    input  logic [lkpc_pkg::RD_W-1:0]       i_reading_a,
    input  logic [lkpc_pkg::RD_W-1:0]       i_reading_b,
    output logic                            o_out_valid,
    input  logic                            i_out_stall,
    output logic [lkpc_pkg::NAME_W-1:0]     o_key_name,
    output logic [lkpc_pkg::KIND_W-1:0]     o_press_kind,
    output logic                            o_last_event,
    input  logic                            i_cfg_valid,
    output logic                            o_cfg_ready,
    input  logic [lkpc_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [lkpc_pkg::CFG_DAT_W-1:0]  i_cfg_data
);

    typedef enum logic [3:0] {
        S_IDLE   = 4'b0001,
        S_DIV_B  = 4'b0010,
        S_DIV_A  = 4'b0100,
        S_UPDATE = 4'b1000
    } t_state;

    t_state                         r_state;
    logic                           r_enable;
    logic [lkpc_pkg::STEP_W-1:0]    r_step;
    logic [lkpc_pkg::SHORT_W-1:0]   r_short;
    logic [lkpc_pkg::LONG_W-1:0]    r_long_ticks;
    logic [lkpc_pkg::RD_W-1:0]      r_ra;
    logic [lkpc_pkg::KEY_W-1:0]     r_key;
    logic [lkpc_pkg::KEY_W-1:0]     r_held;
    logic [lkpc_pkg::LONG_W-1:0]    r_hold;
    logic                           r_long_rep;
    lkpc_pkg::t_event               r_ev0;
    lkpc_pkg::t_event               r_ev1;
    logic [1:0]                     r_pend_cnt;
    lkpc_pkg::t_event               r_out;
    logic                           r_out_valid;

    lkpc_pkg::t_div_ctrl            div_ctrl;
    lkpc_pkg::t_div_status          div_status;
    logic                           in_acc;
    logic                           quot_hit;
    logic                           move;

    logic [lkpc_pkg::LONG_W-1:0]    lt;
    logic                           finish;
    logic [lkpc_pkg::NAME_W-1:0]    fin_name;
    lkpc_pkg::t_event               ev_a;
    lkpc_pkg::t_event               ev_b;
    logic [1:0]                     ev_cnt;
    logic [lkpc_pkg::KEY_W-1:0]     n_held;
    logic [lkpc_pkg::LONG_W-1:0]    n_hold;
    logic                           n_long_rep;

    assign o_cfg_ready = 1'b1;
    assign o_in_stall  = !((r_state == S_IDLE) && (r_pend_cnt == 2'd0));
    assign in_acc      = i_in_valid && !o_in_stall;
    assign quot_hit    = div_status.quot != lkpc_pkg::QUOT_NONE;
    assign move        = (r_pend_cnt != 2'd0) && (!r_out_valid || !i_out_stall);

    assign o_out_valid  = r_out_valid;
    assign o_key_name   = r_out.key_name;
    assign o_press_kind = r_out.press_kind;
    assign o_last_event = r_out.last_event;

    always_comb begin
        div_ctrl.start    = 1'b0;
        div_ctrl.dividend = r_ra;
        if (in_acc) begin
            div_ctrl.start    = 1'b1;
            div_ctrl.dividend = i_reading_b;
        end else if ((r_state == S_DIV_B) && div_status.done && !quot_hit) begin
            div_ctrl.start    = 1'b1;
        end
    end

    lkpc_div u_div (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_ctrl    (div_ctrl),
        .i_divisor (r_step),
        .o_status  (div_status)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_enable     <= lkpc_pkg::RST_ENABLE;
            r_step       <= lkpc_pkg::RST_STEP;
            r_short      <= lkpc_pkg::RST_SHORT;
            r_long_ticks <= lkpc_pkg::RST_LONG;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                lkpc_pkg::CFG_ENABLE: r_enable     <= i_cfg_data[0];
                lkpc_pkg::CFG_STEP:   r_step       <= i_cfg_data;
                lkpc_pkg::CFG_SHORT:  r_short      <= i_cfg_data[lkpc_pkg::SHORT_W-1:0];
                lkpc_pkg::CFG_LONG:   r_long_ticks <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_comb begin
        lt         = (r_long_ticks == '0) ? 10'd1 : r_long_ticks;
        finish     = (r_held != '0) && (r_held != r_key);
        fin_name   = lkpc_pkg::key_name_of(r_held);
        ev_a       = '0;
        ev_b       = '0;
        ev_cnt     = 2'd0;
        n_held     = r_held;
        n_hold     = r_hold;
        n_long_rep = r_long_rep;
        if (finish) begin
            n_long_rep = 1'b0;
            if (r_long_rep) begin
                ev_a   = '{fin_name, lkpc_pkg::KIND_RELEASE, 1'b1};
                ev_cnt = 2'd1;
            end else if (r_hold > {2'b00, r_short}) begin
                ev_a   = '{fin_name, lkpc_pkg::KIND_SHORT, 1'b0};
                ev_b   = '{fin_name, lkpc_pkg::KIND_RELEASE, 1'b1};
                ev_cnt = 2'd2;
            end
        end
        if (r_key == '0) begin
            n_hold = '0;
            n_held = '0;
        end else if (r_held != r_key) begin
            n_hold = 10'd1;
            n_held = r_key;
        end else if (r_hold < lt) begin
            n_hold = r_hold + 10'd1;
        end else if (!r_long_rep) begin
            ev_a       = '{fin_name, lkpc_pkg::KIND_LONG, 1'b1};
            ev_cnt     = 2'd1;
            n_long_rep = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_held     <= '0;
            r_hold     <= '0;
            r_long_rep <= 1'b0;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (in_acc) begin
                        r_state <= S_DIV_B;
                    end
                end
                S_DIV_B: begin
                    if (div_status.done) begin
                        r_state <= quot_hit ? S_UPDATE : S_DIV_A;
                    end
                end
                S_DIV_A: begin
                    if (div_status.done) begin
                        r_state <= S_UPDATE;
                    end
                end
                S_UPDATE: begin
                    r_state    <= S_IDLE;
                    r_held     <= n_held;
                    r_hold     <= n_hold;
                    r_long_rep <= n_long_rep;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_ra <= i_reading_a;
        end
        if ((r_state == S_DIV_B) && div_status.done && quot_hit) begin
            r_key <= {1'b0, div_status.quot} + 4'd5;
        end else if ((r_state == S_DIV_A) && div_status.done) begin
            r_key <= quot_hit ? ({1'b0, div_status.quot} + 4'd1) : '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend_cnt  <= 2'd0;
            r_out_valid <= 1'b0;
        end else begin
            if ((r_state == S_UPDATE) && r_enable) begin
                r_pend_cnt <= ev_cnt;
            end else if (move) begin
                r_pend_cnt <= r_pend_cnt - 2'd1;
            end
            if (move) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_UPDATE) begin
            r_ev0 <= ev_a;
            r_ev1 <= ev_b;
        end else if (move) begin
            r_ev0 <= r_ev1;
        end
        if (move) begin
            r_out <= r_ev0;
        end
    end

    a_accept_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc |=> (r_state == S_DIV_B))
        else $error("accepted item did not start ladder B division");

    a_pend_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_IDLE) |-> (r_pend_cnt == 2'd0))
        else $error("events pending while an item is in work");

    a_long_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_long_rep |-> (r_held != '0))
        else $error("long press flag without a held key");

    a_pend_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pend_cnt != 2'd3)
        else $error("more than two pending events");

endmodule

>>> dv/ladder_keypad_press_classifier_top_tb.sv
// ----------------------------------------------------------------------------
// ladder_keypad_press_classifier_top_tb
// Checks the ladder keypad press classifier against a cycle-free predictor.
// Each accepted tick updates a local model of the held key, the hold count
// and the long-press flag. Every event the block emits is compared with the
// oldest predicted one. The run starts with a short hand-picked tick list.
// It then steps through several register settings with random press, hold,
// release and noise sequences, under varied input gaps and output stalls.
// ----------------------------------------------------------------------------
module ladder_keypad_press_classifier_top_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int KEY_A_FIRST     = 1;
    localparam int KEY_B_FIRST     = 5;
    localparam int NUM_KEYS        = 8;
    localparam int MAX_EVENTS      = 2;
    localparam int RD_MAX          = 2**lkpc_pkg::RD_W - 1;
    localparam int SETTLE_CYCLES   = 20;
    localparam int HOLD_OFF_CYCLES = 400;
    localparam int CYCLE_LIMIT     = 300000;

    typedef logic [lkpc_pkg::RD_W-1:0]      t_reading;
    typedef logic [lkpc_pkg::KEY_W-1:0]     t_key;
    typedef logic [lkpc_pkg::LONG_W-1:0]    t_long;
    typedef logic [lkpc_pkg::NAME_W-1:0]    t_name;
    typedef logic [lkpc_pkg::CFG_IDX_W-1:0] t_cfg_idx;
    typedef logic [lkpc_pkg::CFG_DAT_W-1:0] t_cfg_dat;

    typedef struct packed {
        t_reading ra;
        t_reading rb;
    } t_reading_pair;

    logic                              i_clk       = 1'b0;
    logic                              i_rst_n     = 1'b0;
    logic                              i_in_valid  = 1'b0;
    logic                              o_in_stall;
    t_reading                          i_reading_a = '0;
    t_reading                          i_reading_b = '0;
    logic                              o_out_valid;
    logic                              i_out_stall = 1'b0;
    logic [lkpc_pkg::NAME_W-1:0]       o_key_name;
    logic [lkpc_pkg::KIND_W-1:0]       o_press_kind;
    logic                              o_last_event;
    logic                              i_cfg_valid = 1'b0;
    logic                              o_cfg_ready;
    t_cfg_idx                          i_cfg_index = '0;
    t_cfg_dat                          i_cfg_data  = '0;

    // model of the block
    logic                              en_m        = lkpc_pkg::RST_ENABLE;
    logic [lkpc_pkg::STEP_W-1:0]       step_m      = lkpc_pkg::RST_STEP;
    logic [lkpc_pkg::SHORT_W-1:0]      short_min_m = lkpc_pkg::RST_SHORT;
    t_long                             long_m      = lkpc_pkg::RST_LONG;
    t_key                              held_key_m  = '0;
    t_long                             hold_cnt_m  = '0;
    logic                              long_done_m = 1'b0;

    t_reading_pair     ticks_to_send [$];
    lkpc_pkg::t_event  events_due [$];
    lkpc_pkg::t_event  tick_events [$];

    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    bit hold_off_req   = 1'b0;
    bit hold_off_used  = 1'b0;
    int hold_off_left  = 0;

    int n_sent        = 0;
    int n_ticks_taken = 0;
    int n_events_seen = 0;
    int n_short       = 0;
    int n_long        = 0;
    int n_release     = 0;
    int n_muted       = 0;
    int n_cfg_writes  = 0;
    int n_errors      = 0;
    int n_cycles      = 0;

    ladder_keypad_press_classifier_top i_dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_stall   (o_in_stall),
        .i_reading_a  (i_reading_a),
        .i_reading_b  (i_reading_b),
        .o_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .o_key_name   (o_key_name),
        .o_press_kind (o_press_kind),
        .o_last_event (o_last_event),
        .i_cfg_valid  (i_cfg_valid),
        .o_cfg_ready  (o_cfg_ready),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data)
    );

    always #6 i_clk = ~i_clk;

    function automatic t_key decode_key(input t_reading ra, input t_reading rb);
        int unsigned q;
        if (step_m == '0) begin
            return '0;
        end
        q = rb / step_m;
        if (q < lkpc_pkg::QUOT_NONE) begin
            return t_key'(q + KEY_B_FIRST);
        end
        q = ra / step_m;
        if (q < lkpc_pkg::QUOT_NONE) begin
            return t_key'(q + KEY_A_FIRST);
        end
        return '0;
    endfunction

    function automatic void note_event(input t_key key,
                                       input logic [lkpc_pkg::KIND_W-1:0] kind);
        lkpc_pkg::t_event ev;
        t_name            slot;
        slot          = t_name'(key - 4'd1);
        ev.key_name   = lkpc_pkg::KEY_MAP[slot];
        ev.press_kind = kind;
        ev.last_event = 1'b0;
        if (tick_events.size() < MAX_EVENTS) begin
            tick_events.push_back(ev);
        end
    endfunction

    function automatic void close_held_key();
        if (long_done_m) begin
            note_event(held_key_m, lkpc_pkg::KIND_RELEASE);
            long_done_m = 1'b0;
        end else if (hold_cnt_m > short_min_m) begin
            note_event(held_key_m, lkpc_pkg::KIND_SHORT);
            note_event(held_key_m, lkpc_pkg::KIND_RELEASE);
        end
    endfunction

    function automatic void classify_tick(input t_reading ra, input t_reading rb);
        t_key  key;
        t_long lt;
        key = decode_key(ra, rb);
        lt  = (long_m == '0) ? t_long'(1) : long_m;
        tick_events.delete();
        if (key == '0) begin
            if (held_key_m != '0) begin
                close_held_key();
                hold_cnt_m = '0;
                held_key_m = '0;
            end
        end else begin
            if (held_key_m != key) begin
                if (held_key_m != '0) begin
                    close_held_key();
                end
                hold_cnt_m = '0;
                held_key_m = key;
            end
            if (hold_cnt_m < lt) begin
                hold_cnt_m = hold_cnt_m + 1'b1;
            end else if (!long_done_m) begin
                note_event(held_key_m, lkpc_pkg::KIND_LONG);
                long_done_m = 1'b1;
            end
        end
        if (tick_events.size() > 0) begin
            tick_events[tick_events.size() - 1].last_event = 1'b1;
        end
        foreach (tick_events[k]) begin
            if (!en_m) begin
                n_muted++;
            end else begin
                events_due.push_back(tick_events[k]);
                case (tick_events[k].press_kind)
                    lkpc_pkg::KIND_SHORT: n_short++;
                    lkpc_pkg::KIND_LONG:  n_long++;
                    default:              n_release++;
                endcase
            end
        end
    endfunction

    function automatic void check_field(input string what, input int unsigned want,
                                        input int unsigned got);
        if (want != got) begin
            $display("%0t ns: %s mismatch, expected %0d, actual %0d", $time, what, want, got);
            n_errors++;
        end
    endfunction

    function automatic t_reading reading_at(input int q);
        int lo;
        if (step_m == '0) begin
            return t_reading'($urandom);
        end
        lo = q * int'(step_m);
        return t_reading'($urandom_range(lo + int'(step_m) - 1, lo));
    endfunction

    function automatic t_reading no_key_reading();
        return t_reading'($urandom_range(RD_MAX, int'(lkpc_pkg::QUOT_NONE) * int'(step_m)));
    endfunction

    function automatic void queue_tick(input t_reading ra, input t_reading rb);
        t_reading_pair pair;
        pair.ra = ra;
        pair.rb = rb;
        ticks_to_send.push_back(pair);
        n_sent++;
    endfunction

    function automatic void queue_key(input int key);
        if (key >= KEY_B_FIRST) begin
            queue_tick(t_reading'($urandom), reading_at(key - KEY_B_FIRST));
        end else if (key >= KEY_A_FIRST) begin
            queue_tick(reading_at(key - KEY_A_FIRST), no_key_reading());
        end else begin
            queue_tick(no_key_reading(), no_key_reading());
        end
    endfunction

    task automatic queue_presses(input int n_ticks);
        int target;
        int lt;
        int pick;
        int hold_len;
        target = n_sent + n_ticks;
        lt     = (long_m == '0) ? 1 : int'(long_m);
        while (n_sent < target) begin
            if ($urandom_range(99) < 20) begin
                repeat ($urandom_range(3, 1)) begin
                    queue_tick(t_reading'($urandom), t_reading'($urandom));
                end
            end else begin
                pick = $urandom_range(99);
                if (pick < 35) begin
                    hold_len = $urandom_range(int'(short_min_m) + 3, 1);
                end else if (pick < 70) begin
                    hold_len = $urandom_range(lt + 3, (lt > 2) ? lt - 2 : 1);
                end else begin
                    hold_len = $urandom_range(lt + 6, 1);
                end
                pick = $urandom_range(NUM_KEYS, 1);
                repeat (hold_len) queue_key(pick);
                if ($urandom_range(99) < 60) begin
                    repeat ($urandom_range(3, 1)) queue_key(0);
                end
            end
        end
    endtask

    task automatic write_reg(input t_cfg_idx idx, input t_cfg_dat val);
        @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        n_cfg_writes++;
        case (idx)
            lkpc_pkg::CFG_ENABLE: en_m        = val[0];
            lkpc_pkg::CFG_STEP:   step_m      = val[lkpc_pkg::STEP_W-1:0];
            lkpc_pkg::CFG_SHORT:  short_min_m = val[lkpc_pkg::SHORT_W-1:0];
            lkpc_pkg::CFG_LONG:   long_m      = val[lkpc_pkg::LONG_W-1:0];
            default:              ;
        endcase
    endtask

    task automatic settle();
        while (n_ticks_taken != n_sent || events_due.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    always @(posedge i_clk) begin
        t_reading_pair pair;
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else if (!i_in_valid || !o_in_stall) begin
            if (ticks_to_send.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
                pair = ticks_to_send.pop_front();
                i_in_valid  <= 1'b1;
                i_reading_a <= pair.ra;
                i_reading_b <= pair.rb;
            end else begin
                i_in_valid <= 1'b0;
            end
        end
    end

    always @(posedge i_clk) begin
        if (hold_off_req && !hold_off_used) begin
            hold_off_used = 1'b1;
            hold_off_left = HOLD_OFF_CYCLES;
        end
        if (hold_off_left > 0) begin
            hold_off_left--;
            i_out_stall <= 1'b1;
        end else begin
            i_out_stall <= ($urandom_range(99) < recv_stall_pct);
        end
    end

    always @(posedge i_clk) begin
        lkpc_pkg::t_event want;
        if (i_rst_n) begin
            if (i_in_valid && !o_in_stall) begin
                classify_tick(i_reading_a, i_reading_b);
                n_ticks_taken++;
            end
            if (o_out_valid && !i_out_stall) begin
                n_events_seen++;
                if (events_due.size() == 0) begin
                    $display("%0t ns: unexpected event, expected none, actual key %0d kind %0d last %0d",
                             $time, o_key_name, o_press_kind, o_last_event);
                    n_errors++;
                end else begin
                    want = events_due.pop_front();
                    check_field("key_name", want.key_name, o_key_name);
                    check_field("press_kind", want.press_kind, o_press_kind);
                    check_field("last_event", want.last_event, o_last_event);
                end
            end
        end
    end

    always @(posedge i_clk) begin
        n_cycles++;
        if (n_cycles > CYCLE_LIMIT) begin
            $display("[ladder_keypad_press_classifier_top] ERROR");
            $finish;
        end
    end

    initial begin
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        write_reg(lkpc_pkg::CFG_SHORT, 10'd1);
        write_reg(lkpc_pkg::CFG_LONG, 10'd3);
        queue_tick(12'd0, 12'd4095);
        queue_tick(12'd0, 12'd4095);
        queue_tick(12'd0, 12'd4095);
        queue_tick(12'd0, 12'd4095);
        queue_tick(12'd4095, 12'd4095);
        queue_tick(12'd929, 12'd4095);
        queue_tick(12'd930, 12'd4095);
        queue_tick(12'd1860, 12'd4095);
        queue_tick(12'd3719, 12'd4095);
        queue_tick(12'd3719, 12'd4095);
        queue_tick(12'd3720, 12'd3720);
        queue_tick(12'd0, 12'd0);
        queue_tick(12'd4095, 12'd930);
        queue_tick(12'd4095, 12'd1860);
        queue_tick(12'd4095, 12'd3719);
        queue_tick(12'd4095, 12'd3719);
        queue_tick(12'd4095, 12'd2790);
        queue_tick(12'd2048, 12'd2790);
        queue_tick(12'd0, 12'd1859);
        queue_tick(12'd0, 12'd1859);
        queue_tick(12'd930, 12'd0);
        queue_tick(12'd4095, 12'd4095);
        settle();

        write_reg(lkpc_pkg::CFG_STEP, 10'd820);
        write_reg(lkpc_pkg::CFG_SHORT, 10'd0);
        write_reg(lkpc_pkg::CFG_LONG, 10'd1);
        queue_presses(140);
        hold_off_req = 1'b1;
        settle();

        send_idle_pct = 54;
        write_reg(lkpc_pkg::CFG_STEP, 10'd1023);
        write_reg(lkpc_pkg::CFG_SHORT, 10'd2);
        write_reg(lkpc_pkg::CFG_LONG, 10'd6);
        queue_presses(140);
        settle();

        send_idle_pct  = 0;
        recv_stall_pct = 54;
        for (int k = int'(lkpc_pkg::CFG_LONG) + 1; k < 2**lkpc_pkg::CFG_IDX_W; k++) begin
            write_reg(t_cfg_idx'(k), t_cfg_dat'($urandom));
        end
        write_reg(lkpc_pkg::CFG_STEP, 10'd900);
        write_reg(lkpc_pkg::CFG_SHORT, 10'd5);
        write_reg(lkpc_pkg::CFG_LONG, 10'd12);
        queue_presses(140);
        settle();

        send_idle_pct  = 24;
        recv_stall_pct = 24;
        write_reg(lkpc_pkg::CFG_ENABLE, 10'h3FE);
        write_reg(lkpc_pkg::CFG_STEP, t_cfg_dat'($urandom_range(1023, 820)));
        queue_presses(100);
        settle();

        send_idle_pct  = 54;
        recv_stall_pct = 0;
        write_reg(lkpc_pkg::CFG_ENABLE, 10'd1);
        write_reg(lkpc_pkg::CFG_LONG, 10'd0);
        write_reg(lkpc_pkg::CFG_SHORT, 10'd0);
        queue_presses(80);
        settle();

        send_idle_pct = 0;
        write_reg(lkpc_pkg::CFG_STEP, 10'd0);
        queue_presses(40);
        settle();

        send_idle_pct  = 24;
        recv_stall_pct = 24;
        write_reg(lkpc_pkg::CFG_STEP, 10'd930);
        write_reg(lkpc_pkg::CFG_SHORT, 10'h3FF);
        write_reg(lkpc_pkg::CFG_LONG, 10'd1023);
        repeat (258) queue_key($urandom_range(KEY_A_FIRST + 3, KEY_A_FIRST));
        queue_key(0);
        repeat (20) queue_key($urandom_range(NUM_KEYS, KEY_B_FIRST));
        queue_key(0);
        settle();

        $display("Sent %0d ticks over eight register settings with %0d config writes.",
                 n_sent, n_cfg_writes);
        $display("Checked %0d events (%0d short, %0d long, %0d release), %0d muted.",
                 n_events_seen, n_short, n_long, n_release, n_muted);
        if (n_errors == 0) begin
            $display("[ladder_keypad_press_classifier_top] OK");
        end else begin
            $display("[ladder_keypad_press_classifier_top] ERROR");
        end
        $finish;
    end

endmodule
